// ----- rtl/core/sfd_pkg.sv -----
// sfd_pkg: shared widths, register codes, reset values and lane control type
// for the stereo feedback delay. No dependencies.
`timescale 1ns / 1ps

package sfd_pkg;

	// payload widths
	localparam int SAMPLE_W   = 16;
	localparam int DELAY_W    = 23;
	localparam int GAIN_W     = 15;
	localparam int FRAC_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	// default storage geometry
	localparam int STORE_DEPTH_DEF = 32768;
	localparam int STORE_WIDTH_DEF = 24;

	// feedback ceiling (0.99 in Q0.15) and unity gain (1.0 in Q1.15)
	localparam logic [GAIN_W-1:0] FEEDBACK_MAX = 15'd32440;
	localparam logic [16:0]       UNITY        = 17'd32768;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LEFT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_RIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX     = 3'd4;

	// register reset values
	localparam logic                 ENABLE_RST   = 1'b0;
	localparam logic [DELAY_W-1:0]   DELAY_RST    = 23'd1694208;
	localparam logic [GAIN_W-1:0]    FEEDBACK_RST = 15'd9830;
	localparam logic [SAMPLE_W-1:0]  WET_MIX_RST  = 16'd16384;

	// per-request strobes from the sequencer to both lanes
	typedef struct packed {
		logic start;   // request accepted, address of first neighbor on the RAM
		logic cap_s0;  // first neighbor on read data, second address on the RAM
		logic interp;  // second neighbor on read data, interpolate
		logic commit;  // write feedback sample and release the result
	} sfd_lane_ctrl_t;

endpackage

// ----- rtl/core/sfd_if.sv -----
// sfd_if: valid/ready channel interfaces for samples, results and register writes.
// Depends on sfd_pkg.
`timescale 1ns / 1ps

interface sfd_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sfd_pkg::SAMPLE_W-1:0]  sample_left;
	logic signed [sfd_pkg::SAMPLE_W-1:0]  sample_right;
	modport source(output valid, sample_left, sample_right, input ready);
	modport sink(input valid, sample_left, sample_right, output ready);
endinterface

interface sfd_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sfd_pkg::SAMPLE_W-1:0]  result_left;
	logic signed [sfd_pkg::SAMPLE_W-1:0]  result_right;
	modport source(output valid, result_left, result_right, input ready);
	modport sink(input valid, result_left, result_right, output ready);
endinterface

interface sfd_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [sfd_pkg::CFG_IDX_W-1:0]      index;
	logic [sfd_pkg::CFG_DATA_W-1:0]     data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/core/stereo_feedback_delay.sv -----
// stereo_feedback_delay: top level, register file, sequencer, write pointer and
// result register merging both lanes. Depends on sfd_pkg, sfd_if and sfd_lane.
`timescale 1ns / 1ps

//  channel   dir  handshake     payload
//  cfg       in   valid/ready   index, data (register write, always ready)
//  samples   in   valid/ready   sample_left, sample_right
//  results   out  valid/ready   result_left, result_right
//
//  An enabled request proceeds as follows: the RAM read of the first neighbor starts in the
//  accept cycle, the second follows, then interpolation and the commit cycle that writes the
//  feedback sample. The single read port of each lane's store sets this order. A disabled
//  request skips to the final state. Reset needs no clearing pass: a wrap flag and the
//  write pointer mark entries never written, which read as zero. A new request is taken
//  while a result waits; the commit cycle holds until the result register is free.

module stereo_feedback_delay #(
	parameter int STORE_DEPTH = sfd_pkg::STORE_DEPTH_DEF,
	parameter int STORE_WIDTH = sfd_pkg::STORE_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	sfd_cfg_if.sink       cfg,
	sfd_sample_if.sink    samples,
	sfd_result_if.source  results
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam logic [AW-1:0] LAST = AW'(STORE_DEPTH - 1);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_READ   = 4'b0010,
		ST_INTERP = 4'b0100,
		ST_FIN    = 4'b1000
	} sfd_state_t;

	sfd_state_t                          state_q;
	logic                                enable_q;
	logic [sfd_pkg::DELAY_W-1:0]         delay_left_q;
	logic [sfd_pkg::DELAY_W-1:0]         delay_right_q;
	logic [sfd_pkg::GAIN_W-1:0]          feedback_q;
	logic signed [sfd_pkg::SAMPLE_W-1:0] wet_mix_q;
	logic [AW-1:0]                       wp_q;
	logic                                wrapped_q;
	logic                                bypass_q;
	logic signed [sfd_pkg::SAMPLE_W-1:0] left_q;
	logic signed [sfd_pkg::SAMPLE_W-1:0] right_q;
	logic                                out_valid_q;
	logic signed [sfd_pkg::SAMPLE_W-1:0] out_left_q;
	logic signed [sfd_pkg::SAMPLE_W-1:0] out_right_q;
	logic signed [sfd_pkg::SAMPLE_W-1:0] lane_left;
	logic signed [sfd_pkg::SAMPLE_W-1:0] lane_right;
	logic                                accept;
	logic                                out_free;
	logic                                finish;
	sfd_pkg::sfd_lane_ctrl_t             ctrl;

	assign cfg.ready     = 1'b1;
	assign samples.ready = (state_q == ST_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign out_free      = !out_valid_q || results.ready;
	assign finish        = (state_q == ST_FIN) && out_free;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= sfd_pkg::ENABLE_RST;
			delay_left_q  <= sfd_pkg::DELAY_RST;
			delay_right_q <= sfd_pkg::DELAY_RST;
			feedback_q    <= sfd_pkg::FEEDBACK_RST;
			wet_mix_q     <= sfd_pkg::WET_MIX_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				sfd_pkg::CFG_ENABLE:      enable_q      <= cfg.data[0];
				sfd_pkg::CFG_DELAY_LEFT:  delay_left_q  <= cfg.data[sfd_pkg::DELAY_W-1:0];
				sfd_pkg::CFG_DELAY_RIGHT: delay_right_q <= cfg.data[sfd_pkg::DELAY_W-1:0];
				sfd_pkg::CFG_FEEDBACK:    feedback_q    <= cfg.data[sfd_pkg::GAIN_W-1:0];
				sfd_pkg::CFG_WET_MIX:     wet_mix_q     <= cfg.data[sfd_pkg::SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			bypass_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						bypass_q <= !enable_q;
						state_q  <= enable_q ? ST_READ : ST_FIN;
					end
				end
				ST_READ:   state_q <= ST_INTERP;
				ST_INTERP: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// input sample latch
	always_ff @(posedge clk) begin
		if (accept) begin
			left_q  <= samples.sample_left;
			right_q <= samples.sample_right;
		end
	end

	always_comb begin
		ctrl.start  = accept && enable_q;
		ctrl.cap_s0 = (state_q == ST_READ);
		ctrl.interp = (state_q == ST_INTERP);
		ctrl.commit = finish && !bypass_q;
	end

	// shared write pointer and wrap flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
		end else if (ctrl.commit) begin
			if (wp_q == LAST) begin
				wp_q      <= '0;
				wrapped_q <= 1'b1;
			end else begin
				wp_q <= wp_q + AW'(1);
			end
		end
	end

	sfd_lane #(
		.STORE_DEPTH(STORE_DEPTH),
		.STORE_WIDTH(STORE_WIDTH)
	) u_lane_left (
		.clk          (clk),
		.ctrl         (ctrl),
		.wp           (wp_q),
		.wrapped      (wrapped_q),
		.delay        (delay_left_q),
		.feedback_gain(feedback_q),
		.wet_mix      (wet_mix_q),
		.sample       (left_q),
		.result       (lane_left)
	);

	sfd_lane #(
		.STORE_DEPTH(STORE_DEPTH),
		.STORE_WIDTH(STORE_WIDTH)
	) u_lane_right (
		.clk          (clk),
		.ctrl         (ctrl),
		.wp           (wp_q),
		.wrapped      (wrapped_q),
		.delay        (delay_right_q),
		.feedback_gain(feedback_q),
		.wet_mix      (wet_mix_q),
		.sample       (right_q),
		.result       (lane_right)
	);

	// result register merging both lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_left_q  <= bypass_q ? left_q : lane_left;
			out_right_q <= bypass_q ? right_q : lane_right;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.result_left  = out_left_q;
	assign results.result_right = out_right_q;

endmodule

// ----- rtl/core/sfd_ram.sv -----
// sfd_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sfd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/sfd_lane.sv -----
// sfd_lane: one channel of the delay: read address, interpolation, feedback
// write and dry/wet mix. Depends on sfd_pkg and sfd_ram.
`timescale 1ns / 1ps

module sfd_lane #(
	parameter int STORE_DEPTH = sfd_pkg::STORE_DEPTH_DEF,
	parameter int STORE_WIDTH = sfd_pkg::STORE_WIDTH_DEF
) (
	input  logic                                clk,
	input  sfd_pkg::sfd_lane_ctrl_t             ctrl,
	input  logic [$clog2(STORE_DEPTH)-1:0]      wp,
	input  logic                                wrapped,
	input  logic [sfd_pkg::DELAY_W-1:0]         delay,
	input  logic [sfd_pkg::GAIN_W-1:0]          feedback_gain,
	input  logic signed [sfd_pkg::SAMPLE_W-1:0] wet_mix,
	input  logic signed [sfd_pkg::SAMPLE_W-1:0] sample,
	output logic signed [sfd_pkg::SAMPLE_W-1:0] result
);

	localparam int AW    = $clog2(STORE_DEPTH);
	localparam int FW    = sfd_pkg::FRAC_W;
	localparam int SW    = STORE_WIDTH;
	localparam int PW    = ((sfd_pkg::DELAY_W > AW + FW) ? sfd_pkg::DELAY_W : AW + FW) + 1;
	localparam int WRW   = SW + 2;
	localparam int MW    = SW + 20;
	localparam logic [PW-1:0] MAX_DELAY = PW'((STORE_DEPTH - 2) * 256);
	localparam logic [PW:0]   SPAN      = (PW + 1)'(STORE_DEPTH * 256);
	localparam logic [AW-1:0] LAST      = AW'(STORE_DEPTH - 1);

	logic [PW-1:0]          d_cl;
	logic [PW:0]            diff;
	logic [PW:0]            pos;
	logic [AW-1:0]          i0_c;
	logic [AW-1:0]          i1_c;
	logic [AW-1:0]          i1_q;
	logic [FW-1:0]          frac_q;
	logic                   v0_q;
	logic                   v1_q;
	logic [AW-1:0]          raddr;
	logic [SW-1:0]          rdata;
	logic signed [SW-1:0]   s0_q;
	logic signed [SW-1:0]   s1;
	logic signed [SW:0]     dif;
	logic signed [SW+9:0]   iprod;
	logic signed [SW:0]     dsum;
	logic signed [SW-1:0]   delayed_q;
	logic [sfd_pkg::GAIN_W-1:0] fb;
	logic signed [SW+15:0]  fprod;
	logic signed [WRW-1:0]  wr;
	logic [SW-1:0]          wdata;
	logic                   neg;
	logic [16:0]            wet;
	logic [16:0]            dry;
	logic signed [SW:0]     w;
	logic signed [33:0]     dprod;
	logic signed [SW+18:0]  wprod;
	logic signed [MW-1:0]   msum;

	// read position: write pointer minus clamped delay, wrapped into the store
	always_comb begin
		d_cl = (PW'(delay) > MAX_DELAY) ? MAX_DELAY : PW'(delay);
		diff = (PW + 1)'({wp, {FW{1'b0}}}) - {1'b0, d_cl};
		pos  = diff[PW] ? diff + SPAN : diff;
		i0_c = pos[AW+FW-1:FW];
		i1_c = (i0_c == LAST) ? '0 : i0_c + AW'(1);
	end

	// keep second address, fraction and fill flags for the request
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			i1_q   <= i1_c;
			frac_q <= pos[FW-1:0];
			v0_q   <= wrapped || (i0_c < wp);
			v1_q   <= wrapped || (i1_c < wp);
		end
	end

	assign raddr = ctrl.start ? i0_c : i1_q;

	sfd_ram #(
		.WIDTH(SW),
		.DEPTH(STORE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ctrl.commit),
		.waddr(wp),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// entries never written since reset read as zero
	always_ff @(posedge clk) begin
		if (ctrl.cap_s0) begin
			s0_q <= v0_q ? $signed(rdata) : '0;
		end
	end

	assign s1 = v1_q ? $signed(rdata) : '0;

	// linear interpolation between neighbors, floor rounding
	always_comb begin
		dif   = (SW + 1)'(s1) - (SW + 1)'(s0_q);
		iprod = dif * $signed({1'b0, frac_q});
		dsum  = (SW + 1)'(s0_q) + (SW + 1)'(iprod >>> FW);
	end

	always_ff @(posedge clk) begin
		if (ctrl.interp) begin
			delayed_q <= dsum[SW-1:0];
		end
	end

	// feedback write value, saturated to the store width
	always_comb begin
		fb    = (feedback_gain > sfd_pkg::FEEDBACK_MAX) ? sfd_pkg::FEEDBACK_MAX : feedback_gain;
		fprod = delayed_q * $signed({1'b0, fb});
		wr    = WRW'(sample) + WRW'(fprod >>> 15);
		if (!wr[WRW-1] && (wr[WRW-2:SW-1] != '0)) begin
			wdata = {1'b0, {(SW - 1){1'b1}}};
		end else if (wr[WRW-1] && (wr[WRW-2:SW-1] != '1)) begin
			wdata = {1'b1, {(SW - 1){1'b0}}};
		end else begin
			wdata = wr[SW-1:0];
		end
	end

	// dry/wet mix, sign of the mix inverts the wet path
	always_comb begin
		neg   = wet_mix[sfd_pkg::SAMPLE_W-1];
		wet   = neg ? 17'(-17'(wet_mix)) : 17'(wet_mix);
		dry   = sfd_pkg::UNITY - wet;
		w     = neg ? -((SW + 1)'(delayed_q)) : (SW + 1)'(delayed_q);
		dprod = $signed({1'b0, dry}) * sample;
		wprod = $signed({1'b0, wet}) * w;
		msum  = (MW'(dprod) + MW'(wprod)) >>> 15;
		if (!msum[MW-1] && (msum[MW-2:15] != '0)) begin
			result = 16'sh7fff;
		end else if (msum[MW-1] && (msum[MW-2:15] != '1)) begin
			result = 16'sh8000;
		end else begin
			result = msum[15:0];
		end
	end

endmodule
